// ===== hdl/cbdr_pkg.sv =====
// Package for the text cell buffer with dirty rectangle.
// Holds the command codes, sequencer states and walker control types.
// Depends on nothing; used by the walker and the top level.
`timescale 1ns / 1ps

package cbdr_pkg;

  // Coordinate widths of the dirty rectangle and the cell walker
  localparam int COL_W = 7;
  localparam int ROW_W = 5;

  // Character written into the blank row of a scroll
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  // Command codes carried by kind
  typedef enum logic [2:0] {
    K_SET       = 3'd0,
    K_GET       = 3'd1,
    K_FILL      = 3'd2,
    K_SCROLL    = 3'd3,
    K_FLUSH     = 3'd4,
    K_READ_DISP = 3'd5
  } kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_CMD,
    ST_READ,
    ST_FILL,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK
  } state_t;

  // Sequencer to walker
  typedef struct packed {
    logic load;
    logic adv;
  } walk_ctl_t;

  // Walker to sequencer
  typedef struct packed {
    logic last;
  } walk_sts_t;

endpackage

// ===== hdl/text_cell_buffer_dirty_rect.sv =====
// Text cell engine with back buffer, display buffer and dirty rectangle.
// Fill, flush and scroll step over their cells with the walker (a flush with nothing
// dirty and a fill out of range skip the walk); the walker writes one cell per cycle.
// busy falls as done rises, so the next item can be accepted in the done cycle.
// After rst a clearing pass over every cell of both buffers runs with busy high.
`timescale 1ns / 1ps

module text_cell_buffer_dirty_rect #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind,
  input  logic [7:0] col_a,
  input  logic [7:0] row_a,
  input  logic [7:0] col_b,
  input  logic [7:0] row_b,
  input  logic [7:0] char_in,
  input  logic [7:0] attr_in,
  output logic       done,
  output logic       ok,
  output logic [7:0] char_out,
  output logic [7:0] attr_out,
  output logic       dirty_pending
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = cbdr_pkg::COL_W;
  localparam int RW    = cbdr_pkg::ROW_W;
  localparam logic [AW-1:0] COLS_A  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_MAX = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_MAX = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_CNT = CW'(COLUMNS);
  localparam logic [RW-1:0] ROW_CNT = RW'(ROWS);
  localparam logic [7:0]    COLS_8  = 8'(COLUMNS);
  localparam logic [7:0]    ROWS_8  = 8'(ROWS);
  localparam logic [7:0]    CMAX_8  = 8'(COLUMNS - 1);
  localparam logic [7:0]    RMAX_8  = 8'(ROWS - 1);

  cbdr_pkg::state_t state, state_next;

  // Latched command
  cbdr_pkg::kind_t c_kind;
  logic [7:0] c_ca, c_ra, c_cb, c_rb, c_ch, c_at;

  // Dirty rectangle
  logic [CW-1:0] dirty_left, dirty_left_next, dirty_right, dirty_right_next;
  logic [RW-1:0] dirty_top, dirty_top_next, dirty_bottom, dirty_bottom_next;

  // Result registers
  logic       done_next, ok_next;
  logic [7:0] char_next, attr_next;

  // Walker
  cbdr_pkg::walk_ctl_t wctl;
  cbdr_pkg::walk_sts_t wsts;
  logic [CW-1:0] wx_lo, wx_hi;
  logic [RW-1:0] wy_lo, wy_hi;
  logic [AW-1:0] walk_addr;

  // Buffers
  logic          back_we, disp_we;
  logic [AW-1:0] back_waddr, disp_waddr;
  logic [15:0]   back_wdata, disp_wdata, back_rdata, disp_rdata;

  // Delayed write stage of a copy
  logic          cp_d, cp_back_d;
  logic [AW-1:0] addr_d;

  // Command decode helpers
  logic          in_rng, fill_on;
  logic [7:0]    fx1, fx2, fy1, fy2, fx2c, fy2c;

  assign busy          = (state != cbdr_pkg::ST_IDLE);
  assign dirty_pending = (dirty_left <= dirty_right) && (dirty_top <= dirty_bottom);

  assign in_rng  = (c_ca < COLS_8) && (c_ra < ROWS_8);
  assign fx1     = (c_ca < c_cb) ? c_ca : c_cb;
  assign fx2     = (c_ca < c_cb) ? c_cb : c_ca;
  assign fy1     = (c_ra < c_rb) ? c_ra : c_rb;
  assign fy2     = (c_ra < c_rb) ? c_rb : c_ra;
  assign fx2c    = (fx2 > CMAX_8) ? CMAX_8 : fx2;
  assign fy2c    = (fy2 > RMAX_8) ? RMAX_8 : fy2;
  assign fill_on = (fx1 < COLS_8) && (fy1 < ROWS_8);

  cbdr_walk #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_walk (
    .clk (clk),
    .ctl (wctl),
    .x_lo(wx_lo),
    .x_hi(wx_hi),
    .y_lo(wy_lo),
    .y_hi(wy_hi),
    .addr(walk_addr),
    .sts (wsts)
  );

  cbdr_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_back (
    .clk  (clk),
    .we   (back_we),
    .waddr(back_waddr),
    .wdata(back_wdata),
    .raddr(walk_addr),
    .rdata(back_rdata)
  );

  cbdr_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_disp (
    .clk  (clk),
    .we   (disp_we),
    .waddr(disp_waddr),
    .wdata(disp_wdata),
    .raddr(walk_addr),
    .rdata(disp_rdata)
  );

  // Hold state, dirty rectangle and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cbdr_pkg::ST_INIT;
      done         <= 1'b0;
      cp_d         <= 1'b0;
      dirty_left   <= COL_CNT;
      dirty_top    <= ROW_CNT;
      dirty_right  <= '0;
      dirty_bottom <= '0;
    end else begin
      state        <= state_next;
      done         <= done_next;
      cp_d         <= (state == cbdr_pkg::ST_COPY);
      dirty_left   <= dirty_left_next;
      dirty_top    <= dirty_top_next;
      dirty_right  <= dirty_right_next;
      dirty_bottom <= dirty_bottom_next;
    end
  end

  // Capture the item, the result payload and the delayed copy address
  always_ff @(posedge clk) begin
    if (state == cbdr_pkg::ST_IDLE && start) begin
      c_kind <= cbdr_pkg::kind_t'(kind);
      c_ca   <= col_a;
      c_ra   <= row_a;
      c_cb   <= col_b;
      c_rb   <= row_b;
      c_ch   <= char_in;
      c_at   <= attr_in;
    end
    ok        <= ok_next;
    char_out  <= char_next;
    attr_out  <= attr_next;
    cp_back_d <= (c_kind == cbdr_pkg::K_SCROLL);
    addr_d    <= (c_kind == cbdr_pkg::K_SCROLL) ? walk_addr - COLS_A : walk_addr;
  end

  // Sequence the commands over the walker and the two buffers
  always_comb begin
    state_next        = state;
    done_next         = 1'b0;
    ok_next           = 1'b1;
    char_next         = '0;
    attr_next         = '0;
    dirty_left_next   = dirty_left;
    dirty_top_next    = dirty_top;
    dirty_right_next  = dirty_right;
    dirty_bottom_next = dirty_bottom;
    wctl              = '0;
    wx_lo             = col_a[CW-1:0];
    wx_hi             = col_a[CW-1:0];
    wy_lo             = row_a[RW-1:0];
    wy_hi             = row_a[RW-1:0];
    back_we           = 1'b0;
    back_waddr        = walk_addr;
    back_wdata        = {c_at, c_ch};
    disp_we           = 1'b0;
    disp_waddr        = walk_addr;
    disp_wdata        = back_rdata;

    // Finish the copy read in the previous cycle
    if (cp_d) begin
      if (cp_back_d) begin
        back_we    = 1'b1;
        back_waddr = addr_d;
        back_wdata = back_rdata;
      end else begin
        disp_we    = 1'b1;
        disp_waddr = addr_d;
      end
    end

    unique case (state)
      cbdr_pkg::ST_INIT: begin
        wctl.load  = 1'b1;
        wx_lo      = '0;
        wx_hi      = COL_MAX;
        wy_lo      = '0;
        wy_hi      = ROW_MAX;
        state_next = cbdr_pkg::ST_CLEAR;
      end
      cbdr_pkg::ST_CLEAR: begin
        back_we    = 1'b1;
        disp_we    = 1'b1;
        back_wdata = '0;
        disp_wdata = '0;
        wctl.adv   = 1'b1;
        if (wsts.last) begin
          state_next = cbdr_pkg::ST_IDLE;
        end
      end
      cbdr_pkg::ST_IDLE: begin
        // Point the walker at the single cell of a set or read
        if (start) begin
          wctl.load  = 1'b1;
          state_next = cbdr_pkg::ST_CMD;
        end
      end
      cbdr_pkg::ST_CMD: begin
        unique case (c_kind)
          cbdr_pkg::K_SET: begin
            if (in_rng) begin
              back_we = 1'b1;
              if (c_ca[CW-1:0] < dirty_left)   dirty_left_next   = c_ca[CW-1:0];
              if (c_ra[RW-1:0] < dirty_top)    dirty_top_next    = c_ra[RW-1:0];
              if (c_ca[CW-1:0] > dirty_right)  dirty_right_next  = c_ca[CW-1:0];
              if (c_ra[RW-1:0] > dirty_bottom) dirty_bottom_next = c_ra[RW-1:0];
            end
            done_next  = 1'b1;
            state_next = cbdr_pkg::ST_IDLE;
          end
          cbdr_pkg::K_GET, cbdr_pkg::K_READ_DISP: begin
            if (in_rng) begin
              state_next = cbdr_pkg::ST_READ;
            end else begin
              ok_next    = 1'b0;
              done_next  = 1'b1;
              state_next = cbdr_pkg::ST_IDLE;
            end
          end
          cbdr_pkg::K_FILL: begin
            if (fill_on) begin
              wctl.load  = 1'b1;
              wx_lo      = fx1[CW-1:0];
              wx_hi      = fx2c[CW-1:0];
              wy_lo      = fy1[RW-1:0];
              wy_hi      = fy2c[RW-1:0];
              if (fx1[CW-1:0] < dirty_left)    dirty_left_next   = fx1[CW-1:0];
              if (fy1[RW-1:0] < dirty_top)     dirty_top_next    = fy1[RW-1:0];
              if (fx2c[CW-1:0] > dirty_right)  dirty_right_next  = fx2c[CW-1:0];
              if (fy2c[RW-1:0] > dirty_bottom) dirty_bottom_next = fy2c[RW-1:0];
              state_next = cbdr_pkg::ST_FILL;
            end else begin
              done_next  = 1'b1;
              state_next = cbdr_pkg::ST_IDLE;
            end
          end
          cbdr_pkg::K_SCROLL: begin
            // Walk the source rows; each cell lands one row up
            wctl.load         = 1'b1;
            wx_lo             = '0;
            wx_hi             = COL_MAX;
            wy_lo             = RW'(1);
            wy_hi             = ROW_MAX;
            dirty_left_next   = '0;
            dirty_top_next    = '0;
            dirty_right_next  = COL_MAX;
            dirty_bottom_next = ROW_MAX;
            state_next        = cbdr_pkg::ST_COPY;
          end
          cbdr_pkg::K_FLUSH: begin
            if (dirty_pending) begin
              wctl.load  = 1'b1;
              wx_lo      = dirty_left;
              wx_hi      = dirty_right;
              wy_lo      = dirty_top;
              wy_hi      = dirty_bottom;
              state_next = cbdr_pkg::ST_COPY;
            end else begin
              done_next  = 1'b1;
              state_next = cbdr_pkg::ST_IDLE;
            end
            dirty_left_next   = COL_CNT;
            dirty_top_next    = ROW_CNT;
            dirty_right_next  = '0;
            dirty_bottom_next = '0;
          end
          default: begin
            done_next  = 1'b1;
            state_next = cbdr_pkg::ST_IDLE;
          end
        endcase
      end
      cbdr_pkg::ST_READ: begin
        if (c_kind == cbdr_pkg::K_READ_DISP) begin
          char_next = disp_rdata[7:0];
          attr_next = disp_rdata[15:8];
        end else begin
          char_next = back_rdata[7:0];
          attr_next = back_rdata[15:8];
        end
        done_next  = 1'b1;
        state_next = cbdr_pkg::ST_IDLE;
      end
      cbdr_pkg::ST_FILL: begin
        back_we  = 1'b1;
        wctl.adv = 1'b1;
        if (wsts.last) begin
          done_next  = 1'b1;
          state_next = cbdr_pkg::ST_IDLE;
        end
      end
      cbdr_pkg::ST_COPY: begin
        wctl.adv = 1'b1;
        if (wsts.last) begin
          state_next = cbdr_pkg::ST_DRAIN;
        end
      end
      cbdr_pkg::ST_DRAIN: begin
        // Last copy write lands now; a scroll goes on to blank the bottom row
        if (c_kind == cbdr_pkg::K_SCROLL) begin
          wctl.load  = 1'b1;
          wx_lo      = '0;
          wx_hi      = COL_MAX;
          wy_lo      = ROW_MAX;
          wy_hi      = ROW_MAX;
          state_next = cbdr_pkg::ST_BLANK;
        end else begin
          done_next  = 1'b1;
          state_next = cbdr_pkg::ST_IDLE;
        end
      end
      cbdr_pkg::ST_BLANK: begin
        back_we    = 1'b1;
        back_wdata = {c_at, cbdr_pkg::BLANK_CHAR};
        wctl.adv   = 1'b1;
        if (wsts.last) begin
          done_next  = 1'b1;
          state_next = cbdr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbdr_pkg::ST_INIT;
      end
    endcase
  end

endmodule

// ===== hdl/cbdr_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the back buffer and the display buffer. No dependencies.
`timescale 1ns / 1ps

module cbdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cbdr_walk.sv =====
// Rectangle walker: steps column by column, row by row over a cell rectangle
// and forms the linear cell address with one shared adder. Uses cbdr_pkg.
`timescale 1ns / 1ps

module cbdr_walk #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  cbdr_pkg::walk_ctl_t             ctl,
  input  logic [cbdr_pkg::COL_W-1:0]      x_lo,
  input  logic [cbdr_pkg::COL_W-1:0]      x_hi,
  input  logic [cbdr_pkg::ROW_W-1:0]      y_lo,
  input  logic [cbdr_pkg::ROW_W-1:0]      y_hi,
  output logic [$clog2(COLUMNS*ROWS)-1:0] addr,
  output cbdr_pkg::walk_sts_t             sts
);

  localparam int AW = $clog2(COLUMNS * ROWS);
  localparam int CW = cbdr_pkg::COL_W;
  localparam int RW = cbdr_pkg::ROW_W;
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  logic [CW-1:0] x;
  logic [CW-1:0] xl;
  logic [CW-1:0] xr;
  logic [RW-1:0] y;
  logic [RW-1:0] yb;
  logic [AW-1:0] row_base;

  // Shared address adder
  assign addr     = row_base + AW'(x);
  assign sts.last = (x == xr) && (y == yb);

  // Load bounds, or advance one cell and wrap to the next row
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x        <= x_lo;
      xl       <= x_lo;
      xr       <= x_hi;
      y        <= y_lo;
      yb       <= y_hi;
      row_base <= AW'(AW'(y_lo) * COLS_A);
    end else if (ctl.adv) begin
      if (x == xr) begin
        x        <= xl;
        y        <= y + RW'(1);
        row_base <= row_base + COLS_A;
      end else begin
        x <= x + CW'(1);
      end
    end
  end

endmodule
